// ===== rtl/core/sfsc_pkg.sv =====
// Shared constants and types for the subsequence-free substring counter.
`default_nettype none
package sfsc_pkg;

   // Sizing of the pattern and text
   localparam int PATTERN_MAX = 8;
   localparam int MAX_LEN     = 1048576;
   localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 21;
   localparam int COUNT_W = 40;
   localparam int LEN_W   = 4;
   localparam int CHARS_W = 64;

   // Control/status register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_CHARS  = 2'd1;

   // One text beat presented to the scan stage
   typedef struct packed {
      logic              fire;
      logic [BYTE_W-1:0] text_byte;
      logic              last;
   } step_type;

   // Result of the string ending at the current beat
   typedef struct packed {
      logic [COUNT_W-1:0] free_count;
      logic               too_long;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/core/sfsc_scan.sv =====
// Prefix-start cells, position, running count and overflow flag for one string.
`default_nettype none
module sfsc_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sfsc_pkg::step_type          step,
   input  wire logic [sfsc_pkg::LEN_W-1:0]  pattern_length,
   input  wire logic [sfsc_pkg::CHARS_W-1:0] pattern_chars,
   output sfsc_pkg::result_type             result
);

   logic [sfsc_pkg::POS_W-1:0]   start_ff [sfsc_pkg::PATTERN_MAX];
   logic [sfsc_pkg::POS_W-1:0]   start_in [sfsc_pkg::PATTERN_MAX];
   logic [sfsc_pkg::POS_W-1:0]   position_ff;
   logic [sfsc_pkg::POS_W-1:0]   position_in;
   logic [sfsc_pkg::COUNT_W-1:0] count_ff;
   logic [sfsc_pkg::COUNT_W-1:0] count_in;
   logic                         overflow_ff;

   logic [sfsc_pkg::LEN_W-1:0]   used_len;
   logic [sfsc_pkg::IDX_W-1:0]   tail_idx;
   logic [sfsc_pkg::POS_W-1:0]   tail_start;
   logic [sfsc_pkg::POS_W-1:0]   gap;
   logic                         full;

   // Clamp the pattern length into 1..PATTERN_MAX
   always_comb begin
      if (pattern_length == '0) begin
         used_len = sfsc_pkg::LEN_W'(1);
      end else if (pattern_length > sfsc_pkg::LEN_W'(sfsc_pkg::PATTERN_MAX)) begin
         used_len = sfsc_pkg::LEN_W'(sfsc_pkg::PATTERN_MAX);
      end else begin
         used_len = pattern_length;
      end
   end

   assign tail_idx    = sfsc_pkg::IDX_W'(used_len - sfsc_pkg::LEN_W'(1));
   assign full        = (position_ff >= sfsc_pkg::POS_W'(sfsc_pkg::MAX_LEN));
   assign position_in = position_ff + sfsc_pkg::POS_W'(1);

   // Shift matched starts one prefix deeper, all cells from their old values
   always_comb begin
      for (int k = 0; k < sfsc_pkg::PATTERN_MAX; k++) begin
         start_in[k] = start_ff[k];
         if ((k < int'(used_len)) &&
             (step.text_byte == pattern_chars[sfsc_pkg::BYTE_W*k +: sfsc_pkg::BYTE_W])) begin
            if (k == 0) begin
               start_in[k] = position_in;
            end else begin
               start_in[k] = start_ff[k-1];
            end
         end
      end
   end

   // Add the substrings ending here that miss the full pattern
   assign tail_start = start_in[tail_idx];
   assign gap        = position_in - tail_start;
   assign count_in   = count_ff + sfsc_pkg::COUNT_W'(gap);

   assign result.free_count = full ? count_ff : count_in;
   assign result.too_long   = overflow_ff | full;

   // Advance per beat until full, then flag overflow; drop all state at string end
   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last)) begin
         for (int k = 0; k < sfsc_pkg::PATTERN_MAX; k++) begin
            start_ff[k] <= '0;
         end
         position_ff <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (step.fire) begin
         if (full) begin
            overflow_ff <= 1'b1;
         end else begin
            for (int k = 0; k < sfsc_pkg::PATTERN_MAX; k++) begin
               start_ff[k] <= start_in[k];
            end
            position_ff <= position_in;
            count_ff    <= count_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/subsequence_free_substring_count_core.sv =====
// Top level of the streaming subsequence-free substring counter.
//
// Usage: write pattern_length (index 0) and pattern_chars (index 1, char k in
// bits 8k+7:8k) on the csr_ port while no string is in flight. Then stream
// text bytes on the req_ channel, one beat per byte, req_last on the final
// byte. For each string one beat leaves on the rsp_ channel: the number of
// substrings that do not contain the pattern as a subsequence, and a flag
// set when the string ran past 1048576 bytes (later bytes are not counted).
//
// Throughput: one byte per cycle, but a last byte waits for a free result
// register. A byte is held in an input register; the prefix cells and count
// update from it, and a last byte loads the result register on the same
// edge, raising rsp_valid. The cell update and 40-bit count add set the cycle.
//
// Reset clears the counters and sets pattern_length to 1, pattern_chars to 0.
// When the receiver stalls, the result register holds; the input register
// still takes bytes of the next string and stops only at its last byte,
// until the waiting result is taken.
`default_nettype none
module subsequence_free_substring_count_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [sfsc_pkg::BYTE_W-1:0]     req_text_byte,
   input  wire logic                            req_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [sfsc_pkg::COUNT_W-1:0]         rsp_free_count,
   output logic                                 rsp_too_long,
   input  wire logic                            csr_write_enable,
   input  wire logic [sfsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfsc_pkg::CSR_DATA_W-1:0] csr_write_data
);

   logic [sfsc_pkg::LEN_W-1:0]   len_ff;
   logic [sfsc_pkg::CHARS_W-1:0] chars_ff;

   logic                         stage_valid_ff;
   logic [sfsc_pkg::BYTE_W-1:0]  stage_byte_ff;
   logic                         stage_last_ff;
   logic                         stage_go;
   logic                         out_free;

   logic                         rsp_valid_ff;
   logic [sfsc_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                         rsp_long_ff;

   sfsc_pkg::step_type           step;
   sfsc_pkg::result_type         result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= sfsc_pkg::LEN_W'(1);
         chars_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sfsc_pkg::CSR_PATTERN_LENGTH: len_ff   <= csr_write_data[sfsc_pkg::LEN_W-1:0];
            sfsc_pkg::CSR_PATTERN_CHARS:  chars_ff <= csr_write_data[sfsc_pkg::CHARS_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: a last byte waits only for a free result register
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stage_go  = stage_valid_ff && (!stage_last_ff || out_free);
   assign req_ready = !stage_valid_ff || stage_go;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_byte_ff <= req_text_byte;
         stage_last_ff <= req_last;
      end
   end

   assign step.fire      = stage_go;
   assign step.text_byte = stage_byte_ff;
   assign step.last      = stage_last_ff;

   sfsc_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .pattern_length (len_ff),
      .pattern_chars  (chars_ff),
      .result         (result)
   );

   // Result register: load on a last byte, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_go && stage_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go && stage_last_ff) begin
         rsp_count_ff <= result.free_count;
         rsp_long_ff  <= result.too_long;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_free_count = rsp_count_ff;
   assign rsp_too_long   = rsp_long_ff;

   // A last byte stays put while the previous result is stalled
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && stage_last_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while last byte blocked by stalled result");

   // Every accepted beat lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> stage_valid_ff)
      else $error("accepted byte lost from input register");

   // A result appears only after a last byte has been processed
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stage_valid_ff && stage_last_ff))
      else $error("result raised without a last byte");

endmodule
`default_nettype wire

// ===== tb/subsequence_free_substring_count_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the subsequence-free substring counter core.
module subsequence_free_substring_count_core_tb;

   typedef logic [sfsc_pkg::BYTE_W-1:0] text_q_type [$];

   // Indexes past the register map, which the block must ignore
   localparam logic [sfsc_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sfsc_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int MAX_GAP     = 11;
   localparam int LONG_HOLD   = 300;
   localparam int QUIET_LIMIT = 2000;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [sfsc_pkg::BYTE_W-1:0]     req_text_byte;
   logic                            req_last;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [sfsc_pkg::COUNT_W-1:0]    rsp_free_count;
   logic                            rsp_too_long;
   logic                            csr_write_enable;
   logic [sfsc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sfsc_pkg::CSR_DATA_W-1:0] csr_write_data;

   // Shadow registers and scan state of the counter
   logic [sfsc_pkg::LEN_W-1:0]   pat_len_reg;
   logic [sfsc_pkg::CHARS_W-1:0] pat_chars_reg;
   logic [sfsc_pkg::POS_W-1:0]   match_start [sfsc_pkg::PATTERN_MAX];
   logic [sfsc_pkg::POS_W-1:0]   scan_pos;
   logic [sfsc_pkg::COUNT_W-1:0] free_total;
   logic                         overflow_flag;
   sfsc_pkg::result_type         expected_counts [$];

   bit sender_idle_on;
   bit receiver_stall_on;
   bit hold_off_request;
   int mismatch_count;
   int strings_checked;
   int bytes_sent;
   int settings_used;

   subsequence_free_substring_count_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_free_count   (rsp_free_count),
      .rsp_too_long     (rsp_too_long),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Pattern length in use: zero counts as one, large values saturate
   function automatic int active_length();
      if (pat_len_reg == '0) return 1;
      if (int'(pat_len_reg) > sfsc_pkg::PATTERN_MAX) return sfsc_pkg::PATTERN_MAX;
      return int'(pat_len_reg);
   endfunction

   task automatic clear_scan();
      foreach (match_start[k]) match_start[k] = '0;
      scan_pos      = '0;
      free_total    = '0;
      overflow_flag = 1'b0;
   endtask

   // Advance the greedy prefix starts by one byte; queue the count at the last byte
   task automatic scan_byte(input logic [sfsc_pkg::BYTE_W-1:0] c, input logic is_last);
      logic [sfsc_pkg::POS_W-1:0] prev [sfsc_pkg::PATTERN_MAX];
      logic [sfsc_pkg::POS_W-1:0] p;
      int                         m;
      sfsc_pkg::result_type       r;
      if (int'(scan_pos) >= sfsc_pkg::MAX_LEN) begin
         overflow_flag = 1'b1;
      end else begin
         m    = active_length();
         prev = match_start;
         p    = scan_pos + 1'b1;
         for (int k = 0; k < m; k++) begin
            if (c == pat_chars_reg[8*k +: 8]) begin
               if (k == 0) match_start[k] = p;
               else match_start[k] = prev[k-1];
            end
         end
         scan_pos   = p;
         free_total = free_total + (sfsc_pkg::COUNT_W'(p) -
                                    sfsc_pkg::COUNT_W'(match_start[m-1]));
      end
      if (is_last) begin
         r.free_count = free_total;
         r.too_long   = overflow_flag;
         expected_counts.push_back(r);
         clear_scan();
      end
   endtask

   // Offer one text beat, after a random gap if sender idling is on, and hold it until taken
   task automatic send_byte(input logic [sfsc_pkg::BYTE_W-1:0] c, input logic is_last);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= c;
      req_last      <= is_last;
      do @(posedge clock); while (!req_ready);
      scan_byte(c, is_last);
      bytes_sent++;
   endtask

   task automatic send_text(input text_q_type text);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // Drop valid and wait until every queued count has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sfsc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sfsc_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == sfsc_pkg::CSR_PATTERN_LENGTH) pat_len_reg = data[sfsc_pkg::LEN_W-1:0];
      else if (idx == sfsc_pkg::CSR_PATTERN_CHARS) pat_chars_reg = data;
   endtask

   // Load length (with junk in the unused upper bits) and characters
   task automatic set_pattern(input int len, input logic [sfsc_pkg::CHARS_W-1:0] chars);
      logic [sfsc_pkg::CSR_DATA_W-1:0] data;
      data                      = {$urandom, $urandom};
      data[sfsc_pkg::LEN_W-1:0] = len[sfsc_pkg::LEN_W-1:0];
      write_csr(sfsc_pkg::CSR_PATTERN_LENGTH, data);
      write_csr(sfsc_pkg::CSR_PATTERN_CHARS, chars);
      settings_used++;
   endtask

   // Mostly a small alphabet so that text bytes hit pattern characters often
   function automatic logic [sfsc_pkg::CHARS_W-1:0] random_pattern();
      logic [sfsc_pkg::CHARS_W-1:0] chars;
      logic [7:0]                   base;
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      base = 8'($urandom);
      for (int k = 0; k < sfsc_pkg::PATTERN_MAX; k++) begin
         chars[8*k +: 8] = base + 8'($urandom_range(0, 3));
      end
      return chars;
   endfunction

   // Walk the pattern in order, mixed with stray pattern characters and noise
   task automatic send_random_string(input int max_len);
      int         len;
      int         cursor;
      int         pick;
      int         sel;
      logic [7:0] c;
      len    = $urandom_range(1, max_len);
      cursor = 0;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            c      = pat_chars_reg[8*cursor +: 8];
            cursor = (cursor + 1) % active_length();
         end else if (pick < 8) begin
            sel = $urandom_range(0, active_length() - 1);
            c   = pat_chars_reg[8*sel +: 8];
         end else begin
            c = 8'($urandom);
         end
         send_byte(c, i == len - 1);
      end
   endtask

   task automatic test_default_registers();
      text_q_type t;
      t = {8'h00};
      send_text(t);
      t = {8'hFF};
      send_text(t);
      t = {8'h12, 8'h00, 8'h34};
      send_text(t);
   endtask

   task automatic test_pattern_extremes();
      text_q_type t;
      settle();
      set_pattern(sfsc_pkg::PATTERN_MAX, '1);
      t = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_text(t);
      // zero length behaves as one character
      settle();
      set_pattern(0, 64'h0000_0000_0000_6261);
      t = {8'h62, 8'h61, 8'h61};
      send_text(t);
      // lengths past the maximum saturate
      settle();
      set_pattern(15, 64'h0807_0605_0403_0201);
      t = {8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h00};
      send_text(t);
      settle();
      set_pattern(9, 64'h0102_0102_0102_0102);
      t = {8'h02, 8'h01, 8'h02};
      send_text(t);
   endtask

   task automatic test_spare_indexes();
      text_q_type t;
      settle();
      set_pattern(2, 64'h0000_0000_0000_4241);
      write_csr(CSR_SPARE_2, '1);
      write_csr(CSR_SPARE_3, {$urandom, $urandom});
      t = {8'h41, 8'h42, 8'h41};
      send_text(t);
   endtask

   // Fill the block while the receiver holds off, then pause until it drains
   task automatic test_backpressure();
      settle();
      set_pattern(3, random_pattern());
      sender_idle_on   = 1'b0;
      hold_off_request = 1'b1;
      repeat (8) send_random_string(6);
      settle();
      sender_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int sent_here;
      int phase;
      int len_choice;
      int start_bytes;
      sent_here = 0;
      phase     = 0;
      while (sent_here < 870) begin
         settle();
         case (phase)
            0: len_choice = 1;
            1: len_choice = sfsc_pkg::PATTERN_MAX;
            default: len_choice = ($urandom_range(0, 4) == 0) ?
                                  $urandom_range(0, 15) :
                                  $urandom_range(1, sfsc_pkg::PATTERN_MAX);
         endcase
         set_pattern(len_choice, random_pattern());
         sender_idle_on    = ($urandom_range(0, 3) != 0);
         receiver_stall_on = ($urandom_range(0, 3) != 0);
         start_bytes       = bytes_sent;
         repeat ($urandom_range(4, 10)) begin
            send_random_string(($urandom_range(0, 4) == 0) ? 60 : 16);
         end
         sent_here += bytes_sent - start_bytes;
         phase++;
      end
   endtask

   // Receiver: random ready gaps per beat when stalls are on, one long hold-off on request
   initial begin
      int gap;
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_request) begin
            gap              = LONG_HOLD;
            hold_off_request = 1'b0;
         end else begin
            gap = receiver_stall_on ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && !hold_off_request);
      end
   end

   // Compare each result beat with the oldest expected count
   always @(posedge clock) begin
      sfsc_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            $error("unexpected result beat: free_count %0d too_long %0b",
                   rsp_free_count, rsp_too_long);
            mismatch_count++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_free_count !== want.free_count) begin
               $error("free_count: expected %0d, actual %0d", want.free_count, rsp_free_count);
               mismatch_count++;
            end
            if (rsp_too_long !== want.too_long) begin
               $error("too_long: expected %0b, actual %0b", want.too_long, rsp_too_long);
               mismatch_count++;
            end
            strings_checked++;
         end
      end
   end

   // Abort when neither channel moves a beat for too long
   initial begin
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_text_byte    = '0;
      req_last         = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      pat_len_reg      = sfsc_pkg::LEN_W'(1);
      pat_chars_reg    = '0;
      clear_scan();
      sender_idle_on    = 1'b1;
      receiver_stall_on = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_registers();
      test_pattern_extremes();
      test_spare_indexes();
      test_backpressure();
      test_random_traffic();

      settle();
      repeat (8) @(posedge clock);
      $display("checked %0d strings from %0d text bytes over %0d pattern settings,",
               strings_checked, bytes_sent, settings_used);
      $display("including a long receiver hold-off, drained pauses and odd pattern lengths");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sfsc_pkg.sv
rtl/core/sfsc_scan.sv
rtl/core/subsequence_free_substring_count_core.sv
tb/subsequence_free_substring_count_core_tb.sv
